[hw/rtl/oled_text_glyph_streamer_defines.svh]
// assertion macros shared by the streamer rtl
`ifndef OLED_TEXT_GLYPH_STREAMER_DEFINES_SVH
`define OLED_TEXT_GLYPH_STREAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("oled_text_glyph_streamer: assertion failed");
// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("oled_text_glyph_streamer: assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

[hw/rtl/otgs_pkg.sv]
`timescale 1ns / 1ps

package otgs_pkg;

  // defaults for the top-level parameters
  localparam int GLYPH_WIDTH_DEF = 5;
  localparam int COLUMNS_DEF     = 128;
  localparam int PAGES_DEF       = 8;

  localparam int PAGE_W     = 3;
  localparam int WINDOW_LEN = 6;
  localparam int ROM_COLS   = 5;
  localparam int ROM_CHARS  = 95;
  localparam int ROM_IDX_W  = 7;

  // item commands
  localparam logic CMD_PRINT      = 1'b0;
  localparam logic CMD_SET_CURSOR = 1'b1;

  // character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_FIRST   = 8'h20;
  localparam logic [7:0] CHAR_LAST    = 8'h7e;

  // controller opcodes
  localparam logic [7:0] OP_COLUMN_ADDR = 8'h21;
  localparam logic [7:0] OP_PAGE_ADDR   = 8'h22;

  // slots of the window command sequence
  localparam logic [2:0] SLOT_COL_OP    = 3'd0;
  localparam logic [2:0] SLOT_COL_START = 3'd1;
  localparam logic [2:0] SLOT_COL_END   = 3'd2;
  localparam logic [2:0] SLOT_PAGE_OP   = 3'd3;
  localparam logic [2:0] SLOT_PAGE_START = 3'd4;
  localparam logic [2:0] SLOT_PAGE_END  = 3'd5;

  typedef logic [ROM_COLS*8-1:0] font_row_t;

  // 5x7 font, first column in the top byte
  localparam font_row_t FONT_ROM [ROM_CHARS] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
    40'h4464544c44, 40'h00107c8200, 40'h0000ff0000, 40'h00827c1000, 40'h0006090906
  };

endpackage

[hw/rtl/oled_text_glyph_streamer.sv]
`timescale 1ns / 1ps
// channel | handshake          | payload
// --------+--------------------+-------------------------------------------------
// in      | in_valid, in_ready | command, char_code, page_request, column_request
// out     | out_valid, out_ready | is_command, out_byte, last_byte
//
// one output beat per cycle while out_ready does not stall; a print item is GLYPH_WIDTH+1
// beats, or GLYPH_WIDTH+7 when it wraps (12 at the default width), a newline 6, a set cursor 6
// the byte sequencer, one beat per cycle into the output register, sets the rate
// the next item is taken in the cycle the current item's last beat is loaded
// an item with no beats (rejected set cursor) is absorbed in its accept cycle
// rst is synchronous and clears the cursor, sequencer and output valid
// a stall on out_ready holds the output register and the sequencer in place
`include "oled_text_glyph_streamer_defines.svh"

module oled_text_glyph_streamer #(
  parameter int GLYPH_WIDTH = otgs_pkg::GLYPH_WIDTH_DEF,
  parameter int COLUMNS     = otgs_pkg::COLUMNS_DEF,
  parameter int PAGES       = otgs_pkg::PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] char_code,
  input  logic [7:0] page_request,
  input  logic [7:0] column_request,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_command,
  output logic [7:0] out_byte,
  output logic       last_byte
);

  // sequence position: window slots first, then glyph columns and the spacer
  localparam int SeqW  = $clog2(otgs_pkg::WINDOW_LEN + GLYPH_WIDTH + 1);
  localparam int ColKW = $clog2(otgs_pkg::ROM_COLS);
  localparam int PageW = otgs_pkg::PAGE_W;

  localparam logic [SeqW-1:0] PosGlyph  = SeqW'(otgs_pkg::WINDOW_LEN);
  localparam logic [SeqW-1:0] PosWinEnd = SeqW'(otgs_pkg::WINDOW_LEN - 1);
  localparam logic [SeqW-1:0] PosGlyphEnd = SeqW'(otgs_pkg::WINDOW_LEN + GLYPH_WIDTH);
  localparam logic [7:0] ColLastByte  = 8'(COLUMNS - 1);
  localparam logic [7:0] PageLastByte = 8'(PAGES - 1);
  localparam logic [PageW-1:0] PageMax = PageW'(PAGES - 1);

  // cursor state
  logic [PageW-1:0] page;
  logic [7:0]       column;

  // current job in the byte sequencer
  logic             job_valid;
  logic [SeqW-1:0]  job_pos;
  logic [SeqW-1:0]  job_end;
  logic [PageW-1:0] job_page;
  logic [7:0]       job_col;
  logic             job_print;
  otgs_pkg::font_row_t font_row;

  logic in_fire;
  logic advance;
  logic job_last;

  assign advance  = !out_valid || out_ready;
  assign job_last = job_pos == job_end;
  assign in_ready = !job_valid || (advance && job_last);
  assign in_fire  = in_valid && in_ready;

  // decode of the incoming item against the current cursor
  localparam int ROM_IDX_LOCAL = otgs_pkg::ROM_IDX_W;
  logic             is_newline;
  logic             printable;
  logic             wrap;
  logic             cursor_ok;
  logic [PageW-1:0] page_wrap;
  logic [8:0]       col_reach;
  logic [7:0]       col_base;
  logic [ROM_IDX_LOCAL-1:0] rom_idx;

  always_comb begin
    is_newline = char_code == otgs_pkg::CHAR_NEWLINE;
    printable  = (char_code >= otgs_pkg::CHAR_FIRST) && (char_code <= otgs_pkg::CHAR_LAST);
    col_reach  = {1'b0, column} + 9'(GLYPH_WIDTH);
    wrap       = is_newline || (col_reach >= 9'(COLUMNS));
    page_wrap  = (page == PageMax) ? '0 : page + 1'b1;
    cursor_ok  = ({1'b0, page_request} < 9'(PAGES)) && ({1'b0, column_request} < 9'(COLUMNS));
    col_base   = wrap ? 8'd0 : column;
    rom_idx    = printable ? ROM_IDX_LOCAL'(char_code - otgs_pkg::CHAR_FIRST) : '0;
  end

  // cursor update at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      page   <= '0;
      column <= '0;
    end else if (in_fire) begin
      if (command == otgs_pkg::CMD_SET_CURSOR) begin
        if (cursor_ok) begin
          page   <= page_request[PageW-1:0];
          column <= column_request;
        end
      end else begin
        if (wrap) begin
          page <= page_wrap;
        end
        column <= is_newline ? 8'd0 : col_base + 8'(GLYPH_WIDTH + 1);
      end
    end
  end

  // font rom, synchronous read at accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      font_row <= otgs_pkg::FONT_ROM[rom_idx];
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_fire) begin
      job_valid <= (command == otgs_pkg::CMD_PRINT) || cursor_ok;
    end else if (job_valid && advance && job_last) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_pos <= '0;
    end else if (in_fire) begin
      job_pos <= (command == otgs_pkg::CMD_SET_CURSOR || wrap) ? '0 : PosGlyph;
    end else if (job_valid && advance && !job_last) begin
      job_pos <= job_pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (command == otgs_pkg::CMD_SET_CURSOR) begin
        job_end   <= PosWinEnd;
        job_page  <= page_request[PageW-1:0];
        job_col   <= column_request;
        job_print <= 1'b0;
      end else begin
        job_end   <= is_newline ? PosWinEnd : PosGlyphEnd;
        job_page  <= page_wrap;
        job_col   <= 8'd0;
        job_print <= printable;
      end
    end
  end

  // byte for the current position
  logic [7:0]      row_bytes [otgs_pkg::ROM_COLS];
  logic [SeqW-1:0] glyph_k;
  logic [7:0]      seq_byte;
  logic            seq_cmd;

  always_comb begin
    for (int i = 0; i < otgs_pkg::ROM_COLS; i++) begin
      row_bytes[i] = font_row[(otgs_pkg::ROM_COLS - 1 - i) * 8 +: 8];
    end
    glyph_k  = job_pos - PosGlyph;
    seq_cmd  = job_pos < PosGlyph;
    seq_byte = 8'h00;
    if (seq_cmd) begin
      unique case (job_pos[2:0])
        otgs_pkg::SLOT_COL_OP:     seq_byte = otgs_pkg::OP_COLUMN_ADDR;
        otgs_pkg::SLOT_COL_START:  seq_byte = job_col;
        otgs_pkg::SLOT_COL_END:    seq_byte = ColLastByte;
        otgs_pkg::SLOT_PAGE_OP:    seq_byte = otgs_pkg::OP_PAGE_ADDR;
        otgs_pkg::SLOT_PAGE_START: seq_byte = 8'(job_page);
        otgs_pkg::SLOT_PAGE_END:   seq_byte = PageLastByte;
        default:                   seq_byte = 8'h00;
      endcase
    end else if (job_print && (glyph_k < SeqW'(GLYPH_WIDTH))
                 && (glyph_k < SeqW'(otgs_pkg::ROM_COLS))) begin
      seq_byte = row_bytes[glyph_k[ColKW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && job_valid) begin
      is_command <= seq_cmd;
      out_byte   <= seq_byte;
      last_byte  <= job_last;
    end
  end

  `ASSERT_IMPL(a_pos_in_range, clk, rst, job_valid, job_pos <= job_end)
  `ASSERT_IMPL(a_take_only_at_end, clk, rst, in_ready && job_valid, advance && job_last)
  `ASSERT_IMPL(a_column_bound, clk, rst, 1'b1, {1'b0, column} <= 9'(COLUMNS))
  `ASSERT_IMPL(a_page_bound, clk, rst, 1'b1, {1'b0, page} < 4'(PAGES))
  `ASSERT_NEXT(a_last_frees_input, clk, rst, job_valid && advance && job_last && !in_fire,
    !job_valid)

endmodule

[tb/oled_text_glyph_streamer_tb.sv]
`timescale 1ns / 1ps

module oled_text_glyph_streamer_tb;

  // block geometry, kept at the defaults of the top level
  localparam int GLYPH_W   = 5;
  localparam int NUM_COLS  = 128;
  localparam int NUM_PAGES = 8;
  localparam int FONT_COLS = 5;

  // run control
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 136;
  localparam int PRINT_CAP    = 30;

  // one byte beat toward the display controller
  typedef struct packed {
    logic       is_cmd;
    logic [7:0] value;
    logic       last;
  } beat_t;

  // 5x7 font, first column in the top byte, codes 0x20..0x7e
  localparam logic [39:0] FONT_5X7 [95] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
    40'h4464544c44, 40'h00107c8200, 40'h0000ff0000, 40'h00827c1000, 40'h0006090906
  };

  // dut inputs, all known from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = otgs_pkg::CMD_PRINT;
  logic [7:0] char_code = 8'h00;
  logic [7:0] page_request = 8'h00;
  logic [7:0] column_request = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       is_command;
  logic [7:0] out_byte;
  logic       last_byte;

  // cursor as the display should see it, and the bytes still owed
  logic [2:0] cursor_page = '0;
  logic [7:0] cursor_col = '0;
  int         beats_left;
  beat_t      expected_beats [$];
  beat_t      want_beat;

  // idling on both sides, off for one long stretch of the random traffic
  logic throttle = 1'b1;

  // bookkeeping for the summary and the verdict
  int items_sent;
  int page_wraps;
  int rejected_moves;
  int beats_checked;
  int mismatches;
  int quiet_cycles;

  oled_text_glyph_streamer #(
    .GLYPH_WIDTH(GLYPH_W),
    .COLUMNS    (NUM_COLS),
    .PAGES      (NUM_PAGES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .char_code     (char_code),
    .page_request  (page_request),
    .column_request(column_request),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_command    (is_command),
    .out_byte      (out_byte),
    .last_byte     (last_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one line per mismatch, printing capped so a broken block stays readable
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch at byte %0d: %s got %h, want %h", beats_checked, what, got, want);
    end
  endtask

  // queue one owed byte; the last one of the item carries the end mark
  task automatic push_beat(input logic is_cmd, input logic [7:0] value);
    beat_t b;
    b.is_cmd = is_cmd;
    b.value  = value;
    b.last   = (beats_left == 1);
    expected_beats.push_back(b);
    beats_left--;
  endtask

  // column window then page window, six command bytes
  task automatic push_window(input logic [7:0] page, input logic [7:0] col);
    push_beat(1'b1, otgs_pkg::OP_COLUMN_ADDR);
    push_beat(1'b1, col);
    push_beat(1'b1, 8'(NUM_COLS - 1));
    push_beat(1'b1, otgs_pkg::OP_PAGE_ADDR);
    push_beat(1'b1, page);
    push_beat(1'b1, 8'(NUM_PAGES - 1));
  endtask

  // bytes one accepted item must produce, and the cursor it leaves behind
  task automatic render_item(input logic cmd, input logic [7:0] code,
                             input logic [7:0] page_req, input logic [7:0] col_req);
    logic        newline;
    logic        wrap;
    logic        printable;
    logic [39:0] glyph;
    logic [7:0]  next_page;
    int          k;
    if (cmd == otgs_pkg::CMD_SET_CURSOR) begin
      // out-of-range request: no bytes, cursor untouched
      if (page_req < NUM_PAGES && col_req < NUM_COLS) begin
        beats_left  = 6;
        cursor_page = page_req[2:0];
        cursor_col  = col_req;
        push_window(page_req, col_req);
      end else begin
        rejected_moves++;
      end
    end else begin
      newline   = (code == otgs_pkg::CHAR_NEWLINE);
      wrap      = newline || (int'(cursor_col) + GLYPH_W >= NUM_COLS);
      printable = (code >= otgs_pkg::CHAR_FIRST) && (code <= otgs_pkg::CHAR_LAST);
      beats_left = (wrap ? 6 : 0) + (newline ? 0 : GLYPH_W + 1);
      if (wrap) begin
        // next page modulo the page count, back to column zero
        next_page   = 8'((int'(cursor_page) + 1) % NUM_PAGES);
        cursor_page = next_page[2:0];
        cursor_col  = 8'h00;
        page_wraps++;
        push_window(next_page, 8'h00);
      end
      if (!newline) begin
        // unprintable codes draw as a blank glyph
        glyph = printable ? FONT_5X7[code - otgs_pkg::CHAR_FIRST] : 40'h0;
        for (k = 0; k < GLYPH_W; k++) begin
          push_beat(1'b0, (k < FONT_COLS) ? glyph[39 - 8*k -: 8] : 8'h00);
        end
        push_beat(1'b0, 8'h00);
        cursor_col = cursor_col + 8'(GLYPH_W + 1);
      end
    end
  endtask

  // present one item, hold it until taken, then predict its bytes
  task automatic send_item(input logic cmd, input logic [7:0] code,
                           input logic [7:0] page_req, input logic [7:0] col_req);
    if (throttle && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 25);
    end
    in_valid       <= 1'b1;
    command        <= cmd;
    char_code      <= code;
    page_request   <= page_req;
    column_request <= col_req;
    do @(posedge clk); while (!in_ready);
    render_item(cmd, code, page_req, col_req);
    items_sent++;
  endtask

  // output side: compare each beat with the oldest owed byte, random back-pressure
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("byte with nothing owed, out_byte", out_byte, 8'h00);
      end else begin
        want_beat = expected_beats.pop_front();
        if (is_command !== want_beat.is_cmd) begin
          report_mismatch("is_command", 8'(is_command), 8'(want_beat.is_cmd));
        end
        if (out_byte !== want_beat.value) begin
          report_mismatch("out_byte", out_byte, want_beat.value);
        end
        if (last_byte !== want_beat.last) begin
          report_mismatch("last_byte", 8'(last_byte), 8'(want_beat.last));
        end
      end
      beats_checked++;
    end
    out_ready <= !throttle || ($urandom_range(0, 99) >= 25);
  end

  // watchdog: too long with no beat on either side ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d bytes still owed",
               quiet_cycles, expected_beats.size());
      $display("oled_text_glyph_streamer_tb: FAIL");
      $finish;
    end
  end

  // a glyph straight out of reset, at page 0 column 0
  task automatic test_first_glyph();
    send_item(otgs_pkg::CMD_PRINT, 8'h41, 8'h00, 8'h00);
  endtask

  // ends of the printable range and codes outside it, junk in unused fields
  task automatic test_code_extremes();
    send_item(otgs_pkg::CMD_PRINT, otgs_pkg::CHAR_FIRST, 8'hff, 8'hff);
    send_item(otgs_pkg::CMD_PRINT, otgs_pkg::CHAR_LAST, 8'h00, 8'h80);
    send_item(otgs_pkg::CMD_PRINT, 8'h00, 8'h08, 8'h7f);
    send_item(otgs_pkg::CMD_PRINT, 8'h1f, 8'h07, 8'h00);
    send_item(otgs_pkg::CMD_PRINT, 8'h7f, 8'haa, 8'h55);
    send_item(otgs_pkg::CMD_PRINT, 8'h80, 8'h55, 8'haa);
    send_item(otgs_pkg::CMD_PRINT, 8'hff, 8'hff, 8'hff);
  endtask

  // window corners, then requests out of range that must leave the cursor alone
  task automatic test_cursor_limits();
    send_item(otgs_pkg::CMD_SET_CURSOR, 8'hff, 8'h00, 8'h00);
    send_item(otgs_pkg::CMD_SET_CURSOR, 8'h00, 8'h07, 8'h7f);
    send_item(otgs_pkg::CMD_PRINT, 8'h5a, 8'h00, 8'h00);
    send_item(otgs_pkg::CMD_SET_CURSOR, 8'h41, 8'h08, 8'h00);
    send_item(otgs_pkg::CMD_SET_CURSOR, 8'h41, 8'h00, 8'h80);
    send_item(otgs_pkg::CMD_SET_CURSOR, 8'h0a, 8'hff, 8'hff);
    send_item(otgs_pkg::CMD_PRINT, 8'h21, 8'hff, 8'hff);
  endtask

  // newline from mid page, and newline off the last page back to page 0
  task automatic test_newline();
    send_item(otgs_pkg::CMD_PRINT, otgs_pkg::CHAR_NEWLINE, 8'h03, 8'h10);
    send_item(otgs_pkg::CMD_SET_CURSOR, 8'h00, 8'h07, 8'h28);
    send_item(otgs_pkg::CMD_PRINT, otgs_pkg::CHAR_NEWLINE, 8'h00, 8'h00);
  endtask

  // the last column that still fits a glyph, the first that does not
  task automatic test_column_wrap();
    send_item(otgs_pkg::CMD_SET_CURSOR, 8'h00, 8'h03, 8'd122);
    send_item(otgs_pkg::CMD_PRINT, 8'h67, 8'h00, 8'h00);
    send_item(otgs_pkg::CMD_PRINT, 8'h68, 8'h00, 8'h00);
    send_item(otgs_pkg::CMD_SET_CURSOR, 8'h00, 8'h05, 8'd123);
    send_item(otgs_pkg::CMD_PRINT, otgs_pkg::CHAR_LAST, 8'h00, 8'h00);
  endtask

  // mostly text with newlines and cursor moves, some odd codes and bad moves
  task automatic test_random_traffic();
    int         done;
    int         pick;
    logic [7:0] code;
    logic [7:0] page_req;
    logic [7:0] col_req;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      // a long stretch with no idling in the middle
      throttle = !(done >= 50 && done < 100);
      pick     = $urandom_range(0, 99);
      code     = 8'($urandom_range(0, 255));
      page_req = 8'($urandom_range(0, 255));
      col_req  = 8'($urandom_range(0, 255));
      if (pick < 58) begin
        code = 8'($urandom_range(otgs_pkg::CHAR_FIRST, otgs_pkg::CHAR_LAST));
        send_item(otgs_pkg::CMD_PRINT, code, page_req, col_req);
        done++;
      end else if (pick < 68) begin
        send_item(otgs_pkg::CMD_PRINT, otgs_pkg::CHAR_NEWLINE, page_req, col_req);
        done++;
      end else if (pick < 76) begin
        send_item(otgs_pkg::CMD_PRINT, code, page_req, col_req);
        done++;
      end else if (pick < 92) begin
        // bias toward the right edge so glyph wraps come often
        page_req = 8'($urandom_range(0, NUM_PAGES - 1));
        col_req  = $urandom_range(0, 1) ? 8'($urandom_range(100, NUM_COLS - 1))
                                        : 8'($urandom_range(0, NUM_COLS - 1));
        send_item(otgs_pkg::CMD_SET_CURSOR, code, page_req, col_req);
        done++;
      end else begin
        if ($urandom_range(0, 1)) begin
          page_req = 8'($urandom_range(NUM_PAGES, 255));
        end else begin
          col_req = 8'($urandom_range(NUM_COLS, 255));
        end
        send_item(otgs_pkg::CMD_SET_CURSOR, code, page_req, col_req);
        done++;
      end
    end
    throttle = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_first_glyph();
    test_code_extremes();
    test_cursor_limits();
    test_newline();
    test_column_wrap();
    test_random_traffic();

    // let the owed bytes drain, then a short quiet tail for stray beats
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items with %0d page wraps and %0d rejected cursor moves",
             items_sent, page_wraps, rejected_moves);
    $display("checked %0d controller bytes, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("oled_text_glyph_streamer_tb: PASS");
    end else begin
      $display("oled_text_glyph_streamer_tb: FAIL");
    end
    $finish;
  end

endmodule
